// ----- hw/rtl/rcpa_pkg.sv -----
package rcpa_pkg;

  // Geometry
  localparam int NUM_PAGES = 32768;
  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int TOP_W     = IDX_W + 1;
  localparam int PAGE_W    = 15;
  localparam int COUNT_W   = 8;
  localparam int ALU_W     = (TOP_W > COUNT_W) ? TOP_W : COUNT_W;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_ADD   = 2'd2;
  localparam logic [1:0] MODE_INIT  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  // Shared unit operations
  localparam logic ALU_INC = 1'b0;
  localparam logic ALU_DEC = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PAGE_W-1:0]  page_out;
    logic [COUNT_W-1:0] ref_count;
    logic               released;
  } out_word_t;

  typedef struct packed {
    logic             op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             eq;
    logic             res_zero;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/refcounted_page_allocator.sv -----
// Channel   Ports                        Word
// input     in_valid / in_stall          in_word  (mode, page)
// result    out_valid / out_stall        out_word (status, page_out, ref_count, released)
// config    psel penable pwrite paddr    first_page at byte address 0
//
// Allocate, add and free pass through accept, count/stack memory read and execute
// before the result is registered; a free that releases a page adds a push step.
// Initialize walks every page, one count-memory write per cycle; the last write waits for a free output register.
// After reset the count memory is cleared in a pass over every page with in_stall high.
// A result waits in the output register while out_stall is high; the block holds the
// pending step until that register is free.
module refcounted_page_allocator import rcpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [TOP_W-1:0]   top_r, top_nxt;
  logic [TOP_W-1:0]   sweep_r, sweep_nxt;
  logic               init_r, init_nxt;
  logic               out_valid_r;
  out_word_t          out_r, out_nxt;
  logic               out_load;
  logic               out_free;

  logic [PAGE_W-1:0]  first_page;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  // Memories
  logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
  logic [PAGE_W-1:0]  stk_mem [NUM_PAGES];
  logic [COUNT_W-1:0] cnt_q;
  logic [PAGE_W-1:0]  stk_q;
  logic               mem_re;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               stk_we;
  logic [PAGE_W-1:0]  stk_wdata;
  logic [IDX_W-1:0]   stk_raddr;

  logic               sweep_last;
  logic               sweep_push;
  logic               sweep_go;

  rcpa_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .first_page (first_page)
  );

  rcpa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Count memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (mem_re) begin
      cnt_q <= cnt_mem[page_r[IDX_W-1:0]];
    end
  end

  // Free stack memory: writes always land at the top
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[top_r[IDX_W-1:0]] <= stk_wdata;
    end
    if (mem_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  assign mem_re    = (state_r == S_RD);
  assign stk_raddr = alu_rsp.res[IDX_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  assign sweep_last = (sweep_r == TOP_W'(NUM_PAGES - 1));
  assign sweep_push = init_r && (32'(sweep_r) >= 32'(first_page));
  assign sweep_go   = !sweep_last || !init_r || out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    page_nxt  = page_r;
    top_nxt   = top_r;
    sweep_nxt = sweep_r;
    init_nxt  = init_r;
    out_nxt   = out_r;
    out_load  = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = page_r[IDX_W-1:0];
    cnt_wdata = '0;
    stk_we    = 1'b0;
    stk_wdata = page_r;
    alu_req   = '{op: ALU_INC, a: ALU_W'(top_r), b: '0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_word.mode;
          page_nxt = in_word.page;
          if (in_word.mode == MODE_INIT) begin
            sweep_nxt = '0;
            top_nxt   = '0;
            init_nxt  = 1'b1;
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      // Clear one count per cycle, last may wait on output; initialize also pushes pages from first_page up
      S_SWEEP: begin
        alu_req = '{op: ALU_INC, a: ALU_W'(top_r), b: '0};
        if (sweep_go) begin
          cnt_we    = 1'b1;
          cnt_waddr = sweep_r[IDX_W-1:0];
          if (sweep_push) begin
            stk_we    = 1'b1;
            stk_wdata = PAGE_W'(sweep_r);
            top_nxt   = TOP_W'(alu_rsp.res);
          end
          sweep_nxt = sweep_r + TOP_W'(1);
          if (sweep_last) begin
            state_nxt = S_IDLE;
            if (init_r) begin
              out_load = 1'b1;
              out_nxt  = '{status: ST_OK, page_out: '0, ref_count: '0, released: 1'b0};
            end
          end
        end
      end

      // Address of the stack top for a pop
      S_RD: begin
        alu_req   = '{op: ALU_DEC, a: ALU_W'(top_r), b: '0};
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        unique case (mode_r)
          MODE_ALLOC: alu_req = '{op: ALU_DEC, a: ALU_W'(top_r), b: '0};
          MODE_FREE:  alu_req = '{op: ALU_DEC, a: ALU_W'(cnt_q), b: '0};
          MODE_ADD:   alu_req = '{op: ALU_INC, a: ALU_W'(cnt_q), b: ALU_W'(COUNT_MAX)};
          default:    alu_req = '{op: ALU_INC, a: ALU_W'(top_r), b: '0};
        endcase
        if (out_free) begin
          state_nxt = S_IDLE;
          out_load  = 1'b1;
          unique case (mode_r)
            MODE_ALLOC: begin
              if (alu_rsp.eq) begin
                out_nxt = '{status: ST_EMPTY, page_out: '0, ref_count: '0, released: 1'b0};
              end else begin
                top_nxt = TOP_W'(alu_rsp.res);
                if (32'(stk_q) < NUM_PAGES) begin
                  cnt_we    = 1'b1;
                  cnt_waddr = stk_q[IDX_W-1:0];
                  cnt_wdata = COUNT_W'(1);
                end
                out_nxt = '{status: ST_OK, page_out: stk_q, ref_count: COUNT_W'(1),
                            released: 1'b0};
              end
            end
            MODE_FREE: begin
              if ((page_r < first_page) || (32'(page_r) >= NUM_PAGES)) begin
                out_nxt = '{status: ST_RANGE, page_out: page_r, ref_count: '0,
                            released: 1'b0};
              end else if (alu_rsp.eq) begin
                out_nxt = '{status: ST_ZERO, page_out: page_r, ref_count: '0,
                            released: 1'b0};
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = COUNT_W'(alu_rsp.res);
                if (alu_rsp.res_zero) begin
                  // count hit zero: push in the next step
                  out_load  = 1'b0;
                  state_nxt = S_PUSH;
                end else begin
                  out_nxt = '{status: ST_OK, page_out: page_r,
                              ref_count: COUNT_W'(alu_rsp.res), released: 1'b0};
                end
              end
            end
            MODE_ADD: begin
              if (32'(page_r) >= NUM_PAGES) begin
                out_nxt = '{status: ST_RANGE, page_out: page_r, ref_count: '0,
                            released: 1'b0};
              end else if (alu_rsp.eq) begin
                out_nxt = '{status: ST_SAT, page_out: page_r, ref_count: cnt_q,
                            released: 1'b0};
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = COUNT_W'(alu_rsp.res);
                out_nxt   = '{status: ST_OK, page_out: page_r,
                              ref_count: COUNT_W'(alu_rsp.res), released: 1'b0};
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end

      // Push the released page unless the stack is full
      S_PUSH: begin
        alu_req = '{op: ALU_INC, a: ALU_W'(top_r), b: ALU_W'(NUM_PAGES)};
        if (out_free) begin
          state_nxt = S_IDLE;
          out_load  = 1'b1;
          if (alu_rsp.eq) begin
            out_nxt = '{status: ST_OK, page_out: page_r, ref_count: '0, released: 1'b0};
          end else begin
            stk_we  = 1'b1;
            top_nxt = TOP_W'(alu_rsp.res);
            out_nxt = '{status: ST_OK, page_out: page_r, ref_count: '0, released: 1'b1};
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      top_r       <= '0;
      sweep_r     <= '0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      sweep_r <= sweep_nxt;
      init_r  <= init_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    page_r <= page_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef ASSERT_OFF
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(NUM_PAGES))
    else $error("free stack top beyond page count");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!cnt_we && !stk_we))
    else $error("memory write while idle");

  a_release_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.released) |-> (out_word.status == ST_OK && out_word.ref_count == '0))
    else $error("release word with nonzero count or bad status");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != S_IDLE && $past(state_r) != S_RD))
    else $error("result word from a state that produces none");
`endif

endmodule

// ----- hw/rtl/rcpa_alu.sv -----
module rcpa_alu import rcpa_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W-1:0] sum;

  // Step by one, plus an equality compare on the operand
  always_comb begin
    if (req.op == ALU_DEC) begin
      sum = req.a - ALU_W'(1);
    end else begin
      sum = req.a + ALU_W'(1);
    end
    rsp.res      = sum;
    rsp.eq       = (req.a == req.b);
    rsp.res_zero = (sum == '0);
  end

endmodule

// ----- hw/rtl/rcpa_regs.sv -----
module rcpa_regs import rcpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [PAGE_W-1:0] first_page
);

  logic [PAGE_W-1:0] first_page_r;
  logic              hit;

  // Only register 0 exists; low address bits are the byte lane
  assign hit    = (paddr[CFG_AW-1] == 1'b0);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
    end else if (psel && penable && pwrite && hit) begin
      first_page_r <= pwdata[PAGE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = CFG_DW'(first_page_r);
    end
  end

  assign first_page = first_page_r;

endmodule
